// ===== hw/rtl/lpfp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the length-prefixed frame parser.
// No dependencies; imported by lpfp_core and length_prefixed_frame_parser.

package lpfp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned SHIFT_W  = 24;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned CFG_IDX_W = 2;

    // header byte positions
    localparam logic [POS_W-1:0] POS_MAGIC_FIRST  = 4'd0;
    localparam logic [POS_W-1:0] POS_MAGIC_MID    = 4'd2;
    localparam logic [POS_W-1:0] POS_MAGIC_LAST   = 4'd3;
    localparam logic [POS_W-1:0] POS_VERSION      = 4'd4;
    localparam logic [POS_W-1:0] POS_TYPE         = 4'd5;
    localparam logic [POS_W-1:0] POS_LENGTH_FIRST = 4'd6;
    localparam logic [POS_W-1:0] POS_LENGTH_MID   = 4'd8;
    localparam logic [POS_W-1:0] POS_LENGTH_LAST  = 4'd9;
    localparam logic [POS_W-1:0] HDR_BYTES        = 4'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;

    localparam logic [WORD_W-1:0] RST_MAGIC   = 32'd0;
    localparam logic [BYTE_W-1:0] RST_VERSION = 8'd1;
    localparam logic [WORD_W-1:0] RST_MAX_LEN = 32'd65536;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_MAGIC   = 2'd0,
        ERR_VERSION = 2'd1,
        ERR_LENGTH  = 2'd2
    } t_err;

    typedef struct packed {
        logic [WORD_W-1:0] magic;
        logic [BYTE_W-1:0] version;
        logic [WORD_W-1:0] max_len;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] frame_type;
        logic [WORD_W-1:0] length;
        logic [BYTE_W-1:0] data;
        logic              frame_end;
        t_err              err;
    } t_result;

endpackage

// ===== hw/rtl/lpfp_core.sv =====
`timescale 1ns / 1ps
// Parser state and per-byte step logic: header collection, checks, payload count.
// Depends on lpfp_pkg.

module lpfp_core
    import lpfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output logic              o_emit,
    output t_result           o_result
);

    logic                r_in_payload,  n_in_payload;
    logic [POS_W-1:0]    r_hdr_pos,     n_hdr_pos;
    logic [SHIFT_W-1:0]  r_magic_shift, n_magic_shift;
    logic [SHIFT_W-1:0]  r_len_shift,   n_len_shift;
    logic [BYTE_W-1:0]   r_type_held,   n_type_held;
    logic [WORD_W-1:0]   r_len_held,    n_len_held;
    logic [WORD_W-1:0]   r_remaining,   n_remaining;

    logic [POS_W-1:0]    pos;
    logic [WORD_W-1:0]   magic_word;
    logic [WORD_W-1:0]   len_word;
    logic                last_byte;

    assign pos        = (r_hdr_pos >= HDR_BYTES) ? POS_MAGIC_FIRST : r_hdr_pos;
    assign magic_word = {r_magic_shift, i_byte};
    assign len_word   = {r_len_shift, i_byte};
    assign last_byte  = (r_remaining <= 32'd1);

    always_comb begin
        n_in_payload  = r_in_payload;
        n_hdr_pos     = r_hdr_pos;
        n_magic_shift = r_magic_shift;
        n_len_shift   = r_len_shift;
        n_type_held   = r_type_held;
        n_len_held    = r_len_held;
        n_remaining   = r_remaining;
        o_emit        = 1'b0;
        o_result      = '{kind: KIND_HEADER, frame_type: '0, length: '0, data: '0,
                          frame_end: 1'b0, err: ERR_MAGIC};

        if (r_in_payload) begin
            o_emit              = 1'b1;
            o_result.kind       = KIND_PAYLOAD;
            o_result.frame_type = r_type_held;
            o_result.length     = r_len_held;
            o_result.data       = i_byte;
            o_result.frame_end  = last_byte;
            if (last_byte) begin
                n_remaining   = '0;
                n_in_payload  = 1'b0;
                n_hdr_pos     = POS_MAGIC_FIRST;
                n_magic_shift = '0;
                n_len_shift   = '0;
            end else begin
                n_remaining = r_remaining - 32'd1;
            end
        end else begin
            n_hdr_pos = pos + 4'd1;
            unique case (pos) inside
                [POS_MAGIC_FIRST:POS_MAGIC_MID]: begin
                    n_magic_shift = {r_magic_shift[SHIFT_W-BYTE_W-1:0], i_byte};
                end
                POS_MAGIC_LAST: begin
                    if (magic_word != i_cfg.magic) begin
                        o_emit        = 1'b1;
                        o_result.kind = KIND_ERROR;
                        o_result.err  = ERR_MAGIC;
                        n_hdr_pos     = POS_MAGIC_FIRST;
                        n_magic_shift = '0;
                        n_len_shift   = '0;
                    end
                end
                POS_VERSION: begin
                    if (i_byte != i_cfg.version) begin
                        o_emit        = 1'b1;
                        o_result.kind = KIND_ERROR;
                        o_result.err  = ERR_VERSION;
                        n_hdr_pos     = POS_MAGIC_FIRST;
                        n_magic_shift = '0;
                        n_len_shift   = '0;
                    end
                end
                POS_TYPE: begin
                    n_type_held = i_byte;
                end
                [POS_LENGTH_FIRST:POS_LENGTH_MID]: begin
                    n_len_shift = {r_len_shift[SHIFT_W-BYTE_W-1:0], i_byte};
                end
                POS_LENGTH_LAST: begin
                    o_emit              = 1'b1;
                    o_result.frame_type = r_type_held;
                    o_result.length     = len_word;
                    n_hdr_pos           = POS_MAGIC_FIRST;
                    n_magic_shift       = '0;
                    n_len_shift         = '0;
                    if (len_word > i_cfg.max_len) begin
                        o_result.kind = KIND_ERROR;
                        o_result.err  = ERR_LENGTH;
                    end else begin
                        o_result.kind      = KIND_HEADER;
                        o_result.frame_end = (len_word == '0);
                        n_len_held         = len_word;
                        n_remaining        = len_word;
                        n_in_payload       = (len_word != '0);
                    end
                end
                default: begin
                    n_hdr_pos     = POS_MAGIC_FIRST;
                    n_magic_shift = '0;
                    n_len_shift   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload  <= 1'b0;
            r_hdr_pos     <= POS_MAGIC_FIRST;
            r_magic_shift <= '0;
            r_len_shift   <= '0;
            r_type_held   <= '0;
            r_len_held    <= '0;
            r_remaining   <= '0;
        end else if (i_step) begin
            r_in_payload  <= n_in_payload;
            r_hdr_pos     <= n_hdr_pos;
            r_magic_shift <= n_magic_shift;
            r_len_shift   <= n_len_shift;
            r_type_held   <= n_type_held;
            r_len_held    <= n_len_held;
            r_remaining   <= n_remaining;
        end
    end

    ap_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_pos <= HDR_BYTES - 4'd1)
        else $error("header position out of range");

    ap_payload_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_hdr_pos == POS_MAGIC_FIRST) && (r_remaining != '0))
        else $error("payload state with stale header position or zero count");

    ap_payload_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_in_payload && last_byte |=> !r_in_payload)
        else $error("payload did not end on last byte");

endmodule

// ===== hw/rtl/length_prefixed_frame_parser.sv =====
`timescale 1ns / 1ps
// Top level of the length-prefixed frame parser: input register, output register,
// configuration registers. Depends on lpfp_pkg and lpfp_core.
//
// Usage:
//   Input channel  i_valid / o_stall / i_rx_byte: one stream byte per request.
//   Output channel o_valid / i_stall / o_result_kind ... o_error_code: one result
//   per request. A request moves when valid is high and stall is low.
//   Config channel i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data; ready is
//   always high. Index 0 magic, 1 version, 2 max payload length; 3 is ignored.
//   Write configuration only while the parser is idle.
// Timing:
//   A byte is captured in the input register, then parsed by the step logic; its
//   result, if any, is registered in the output register. One byte per cycle is
//   sustained while the output is not stalled: the step logic is a 32-bit compare
//   and decrement between the input and output registers. Header bytes that give
//   no result never wait on the output register.
// Reset (synchronous, active low): both channels empty, header search at byte 0,
//   configuration back to magic 0, version 1, max length 65536.
// Stall: while the receiver stalls a full output register, a byte that would give
//   a result holds in the input register and o_stall rises; nothing is dropped.

module length_prefixed_frame_parser
    import lpfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,

    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_result_kind,
    output logic [BYTE_W-1:0]    o_message_type,
    output logic [WORD_W-1:0]    o_payload_length,
    output logic [BYTE_W-1:0]    o_data_byte,
    output logic                 o_frame_end,
    output logic [1:0]           o_error_code,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_cfg              r_cfg;

    logic              emit;
    t_result           result;
    logic              out_free;
    logic              step;
    logic              in_take;

    lpfp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_emit   (emit),
        .o_result (result)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign step     = r_in_valid && (!emit || out_free);
    assign o_stall  = r_in_valid && !step;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out <= result;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic   <= RST_MAGIC;
            r_cfg.version <= RST_VERSION;
            r_cfg.max_len <= RST_MAX_LEN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAGIC:   r_cfg.magic   <= i_cfg_data;
                CFG_VERSION: r_cfg.version <= i_cfg_data[BYTE_W-1:0];
                CFG_MAX_LEN: r_cfg.max_len <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result_kind    = r_out.kind;
    assign o_message_type   = r_out.frame_type;
    assign o_payload_length = r_out.length;
    assign o_data_byte      = r_out.data;
    assign o_frame_end      = r_out.frame_end;
    assign o_error_code     = r_out.err;

    ap_stall_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && emit && r_out_valid && i_stall)
        else $error("input stalled without a blocked result");

    ap_stalled_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_in_valid && $stable(r_in_byte))
        else $error("stalled input byte lost");

    ap_error_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == KIND_ERROR) |-> !o_frame_end && (o_data_byte == '0))
        else $error("error result with frame end or data");

    ap_code_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind != KIND_ERROR) |-> (o_error_code == ERR_MAGIC))
        else $error("error code set on non-error result");

endmodule

// ===== tb/lpfp_frame_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for length_prefixed_frame_parser: follows the deframing rules for every
// accepted byte, queues the results due and compares them with the output requests.
// Depends on lpfp_pkg.

module lpfp_frame_checker
    import lpfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_rx_valid,
    input  logic                 i_rx_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,

    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic [1:0]           i_result_kind,
    input  logic [BYTE_W-1:0]    i_message_type,
    input  logic [WORD_W-1:0]    i_payload_length,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_frame_end,
    input  logic [1:0]           i_error_code,

    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,

    output int                   o_mismatches,
    output int                   o_results_due
);

    logic [WORD_W-1:0]  frame_magic;
    logic [BYTE_W-1:0]  frame_version;
    logic [WORD_W-1:0]  max_length;

    logic               in_payload;
    logic [POS_W-1:0]   hdr_pos;
    logic [SHIFT_W-1:0] magic_shift;
    logic [SHIFT_W-1:0] length_shift;
    logic [BYTE_W-1:0]  type_held;
    logic [WORD_W-1:0]  length_held;
    logic [WORD_W-1:0]  bytes_left;

    t_result            results_due[$];
    t_result            oldest;
    int                 mismatch_count = 0;

    task automatic restart_search();
        in_payload   = 1'b0;
        hdr_pos      = POS_MAGIC_FIRST;
        magic_shift  = '0;
        length_shift = '0;
    endtask

    task automatic queue_result(input t_kind kind, input logic [BYTE_W-1:0] mtype,
                                input logic [WORD_W-1:0] len, input logic [BYTE_W-1:0] data,
                                input logic last, input t_err err);
        t_result r;
        r.kind       = kind;
        r.frame_type = mtype;
        r.length     = len;
        r.data       = data;
        r.frame_end  = last;
        r.err        = err;
        results_due.insert(results_due.size(), r);
    endtask

    // error_code reads as ERR_MAGIC (zero) on non-error results
    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] word;
        if (in_payload) begin
            queue_result(KIND_PAYLOAD, type_held, length_held, b, bytes_left <= 1, ERR_MAGIC);
            if (bytes_left <= 1) begin
                bytes_left = '0;
                restart_search();
            end else begin
                bytes_left = bytes_left - 1;
            end
        end else begin
            pos = (hdr_pos >= HDR_BYTES) ? POS_MAGIC_FIRST : hdr_pos;
            hdr_pos = pos + 1'b1;
            if (pos < POS_MAGIC_LAST) begin
                magic_shift = {magic_shift[SHIFT_W-BYTE_W-1:0], b};
            end else if (pos == POS_MAGIC_LAST) begin
                if ({magic_shift, b} != frame_magic) begin
                    queue_result(KIND_ERROR, '0, '0, '0, 1'b0, ERR_MAGIC);
                    restart_search();
                end
            end else if (pos == POS_VERSION) begin
                if (b != frame_version) begin
                    queue_result(KIND_ERROR, '0, '0, '0, 1'b0, ERR_VERSION);
                    restart_search();
                end
            end else if (pos == POS_TYPE) begin
                type_held = b;
            end else if (pos < POS_LENGTH_LAST) begin
                length_shift = {length_shift[SHIFT_W-BYTE_W-1:0], b};
            end else begin
                word = {length_shift, b};
                restart_search();
                if (word > max_length) begin
                    queue_result(KIND_ERROR, type_held, word, '0, 1'b0, ERR_LENGTH);
                end else begin
                    length_held = word;
                    bytes_left  = word;
                    in_payload  = (word != 0);
                    queue_result(KIND_HEADER, type_held, word, '0, word == 0, ERR_MAGIC);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_magic   = RST_MAGIC;
            frame_version = RST_VERSION;
            max_length    = RST_MAX_LEN;
            restart_search();
            type_held     = '0;
            length_held   = '0;
            bytes_left    = '0;
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAGIC:   frame_magic   = i_cfg_data;
                    CFG_VERSION: frame_version = i_cfg_data[BYTE_W-1:0];
                    CFG_MAX_LEN: max_length    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result with none expected, actual kind %0d type %h len %h",
                             $time, i_result_kind, i_message_type, i_payload_length);
                    mismatch_count++;
                end else begin
                    oldest = results_due.pop_front();
                    check_field("result_kind", 32'(oldest.kind), 32'(i_result_kind));
                    check_field("message_type", 32'(oldest.frame_type), 32'(i_message_type));
                    check_field("payload_length", oldest.length, i_payload_length);
                    check_field("data_byte", 32'(oldest.data), 32'(i_data_byte));
                    check_field("frame_end", 32'(oldest.frame_end), 32'(i_frame_end));
                    check_field("error_code", 32'(oldest.err), 32'(i_error_code));
                end
            end
            if (i_rx_valid && !i_rx_stall) begin
                deframe_byte(i_rx_byte);
            end
        end
        o_mismatches  <= mismatch_count;
        o_results_due <= results_due.size();
    end

endmodule

// ===== tb/tb_length_prefixed_frame_parser.sv =====
`timescale 1ns / 1ps
// Testbench top for length_prefixed_frame_parser: drives byte streams of frames, broken
// headers and register settings with random idling; lpfp_frame_checker does the scoring.
// Depends on lpfp_pkg, lpfp_frame_checker and the parser RTL.

module tb_length_prefixed_frame_parser;
    import lpfp_pkg::*;

    localparam int ITEMS_PER_PHASE = 110;
    localparam int NUM_PHASES      = 5;
    localparam int DRAIN_CYCLES    = 6;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [BYTE_W-1:0]    i_rx_byte;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [1:0]           o_result_kind;
    logic [BYTE_W-1:0]    o_message_type;
    logic [WORD_W-1:0]    o_payload_length;
    logic [BYTE_W-1:0]    o_data_byte;
    logic                 o_frame_end;
    logic [1:0]           o_error_code;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;

    int                   mismatches;
    int                   results_due;
    int                   items_sent = 0;
    int                   stall_hold = 0;
    int                   stall_roll;
    bit                   quiet = 1'b0;

    logic [WORD_W-1:0]    cur_magic   = RST_MAGIC;
    logic [BYTE_W-1:0]    cur_version = RST_VERSION;
    logic [WORD_W-1:0]    cur_max     = RST_MAX_LEN;

    length_prefixed_frame_parser uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_kind    (o_result_kind),
        .o_message_type   (o_message_type),
        .o_payload_length (o_payload_length),
        .o_data_byte      (o_data_byte),
        .o_frame_end      (o_frame_end),
        .o_error_code     (o_error_code),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    lpfp_frame_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_valid       (i_valid),
        .i_rx_stall       (o_stall),
        .i_rx_byte        (i_rx_byte),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_result_kind    (o_result_kind),
        .i_message_type   (o_message_type),
        .i_payload_length (o_payload_length),
        .i_data_byte      (o_data_byte),
        .i_frame_end      (o_frame_end),
        .i_error_code     (o_error_code),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatches     (mismatches),
        .o_results_due    (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver back-pressure: mostly short stalls, a few long ones
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_stall    <= 1'b0;
            stall_hold <= 0;
        end else if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 60) begin
                i_stall <= 1'b0;
            end else if (stall_roll < 94) begin
                i_stall    <= 1'b1;
                stall_hold <= $urandom_range(0, 2);
            end else begin
                i_stall    <= 1'b1;
                stall_hold <= $urandom_range(10, 40);
            end
        end
    end

    task automatic send_item(input logic [BYTE_W-1:0] b);
        int roll;
        int gap;
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 70) gap = 0;
        else if (roll < 96) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_word(input logic [WORD_W-1:0] w);
        for (int k = 3; k >= 0; k--) begin
            send_item(w[BYTE_W*k +: BYTE_W]);
        end
    endtask

    task automatic send_header(input logic [WORD_W-1:0] magic, input logic [BYTE_W-1:0] version,
                               input logic [BYTE_W-1:0] mtype, input logic [WORD_W-1:0] len);
        send_word(magic);
        send_item(version);
        send_item(mtype);
        send_word(len);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input logic [WORD_W-1:0] magic, input logic [BYTE_W-1:0] version,
                             input logic [WORD_W-1:0] max_len);
        logic [WORD_W-1:0] junk;
        junk = $urandom;
        write_reg(CFG_MAGIC, magic);
        write_reg(CFG_VERSION, {junk[WORD_W-1:BYTE_W], version});
        write_reg(CFG_SPARE, $urandom);
        write_reg(CFG_MAX_LEN, max_len);
        i_cfg_valid <= 1'b0;
        cur_magic   = magic;
        cur_version = version;
        cur_max     = max_len;
    endtask

    task automatic send_random_frame();
        int                roll;
        int                cap;
        int                len;
        logic [WORD_W-1:0] word;
        logic [BYTE_W-1:0] mtype;
        roll  = $urandom_range(0, 99);
        mtype = 8'($urandom);
        if (roll < 10) begin
            if ($urandom_range(0, 1) != 0) word = $urandom;
            else word = cur_magic ^ (32'd1 << $urandom_range(0, 31));
            if (word == cur_magic) word = ~cur_magic;
            send_word(word);
        end else if (roll < 18) begin
            word[BYTE_W-1:0] = 8'($urandom);
            if (word[BYTE_W-1:0] == cur_version) word[BYTE_W-1:0] = ~cur_version;
            send_word(cur_magic);
            send_item(word[BYTE_W-1:0]);
        end else if (roll < 27 && cur_max != '1) begin
            roll = $urandom_range(0, 2);
            if (roll == 0) word = cur_max + 1;
            else if (roll == 1) word = '1;
            else word = cur_max + 1 + 32'(64'($urandom) % (64'hFFFF_FFFF - 64'(cur_max)));
            send_header(cur_magic, cur_version, mtype, word);
        end else begin
            cap = (cur_max < 12) ? int'(cur_max) : 12;
            len = $urandom_range(0, cap);
            send_header(cur_magic, cur_version, mtype, len);
            repeat (len) send_item(8'($urandom));
        end
    endtask

    initial begin : stimulus
        int ph;
        int phase_start;
        bit paused;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_rx_byte   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_MAGIC;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: empty frame, then a one-byte frame
        send_header(RST_MAGIC, RST_VERSION, 8'hFF, '0);
        send_header(RST_MAGIC, RST_VERSION, 8'h00, 32'd1);
        send_item(8'hFF);
        wait_drained();

        // all-ones magic and version, no payload fits under a zero limit
        configure('1, 8'hFF, '0);
        send_word(32'hFFFF_FFFE);
        send_word('1);
        send_item(8'h00);
        send_header('1, 8'hFF, 8'h5A, '1);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: configure($urandom, 8'($urandom), $urandom_range(0, 12));
                1: configure('0, 8'h00, '1);
                2: configure($urandom, 8'hFF, $urandom_range(0, 3));
                3: configure($urandom, 8'($urandom), $urandom);
                default: configure($urandom, RST_VERSION, RST_MAX_LEN);
            endcase
            phase_start = items_sent;
            paused      = 1'b0;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                send_random_frame();
                if (!paused && items_sent - phase_start >= ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 99) < 15) quiet <= !quiet;
            end
        end

        wait_drained();
        if (mismatches == 0 && results_due == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

endmodule
